// ----- rtl/core/fpld_pkg.sv -----
// Shared types, constants and the log2 lookup table for the decibel level block.
// No dependencies.
package fpld_pkg;

  localparam int unsigned InWidth    = 32;
  localparam int unsigned MagWidth   = 31;
  localparam int unsigned ShiftWidth = 5;
  localparam int unsigned IdxWidth   = 5;
  localparam int unsigned TabWidth   = 15;
  localparam int unsigned ProdWidth  = 32;
  localparam int unsigned OutWidth   = 30;
  localparam int unsigned IdxLsb     = 25;

  // 3.0103 in Q13
  localparam logic [ProdWidth-1:0] DbScaleQ13 = 32'd24660;

  // Item in flight through the normaliser
  typedef struct packed {
    logic                  valid;
    logic                  invalid;
    logic [MagWidth-1:0]   mag;
    logic [ShiftWidth-1:0] shift;
  } norm_t;

  // log2 of (1 + idx/32) plus 30, in Q10
  function automatic logic [TabWidth-1:0] log2_q10(input logic [IdxWidth-1:0] idx);
    logic [TabWidth-1:0] v;
    case (idx)
      5'd0:  v = 15'h7800;
      5'd1:  v = 15'h782d;
      5'd2:  v = 15'h785a;
      5'd3:  v = 15'h7884;
      5'd4:  v = 15'h78ae;
      5'd5:  v = 15'h78d6;
      5'd6:  v = 15'h78fe;
      5'd7:  v = 15'h7924;
      5'd8:  v = 15'h794a;
      5'd9:  v = 15'h796e;
      5'd10: v = 15'h7992;
      5'd11: v = 15'h79b4;
      5'd12: v = 15'h79d6;
      5'd13: v = 15'h79f8;
      5'd14: v = 15'h7a18;
      5'd15: v = 15'h7a38;
      5'd16: v = 15'h7a57;
      5'd17: v = 15'h7a75;
      5'd18: v = 15'h7a93;
      5'd19: v = 15'h7ab1;
      5'd20: v = 15'h7acd;
      5'd21: v = 15'h7ae9;
      5'd22: v = 15'h7b05;
      5'd23: v = 15'h7b20;
      5'd24: v = 15'h7b3b;
      5'd25: v = 15'h7b55;
      5'd26: v = 15'h7b6f;
      5'd27: v = 15'h7b88;
      5'd28: v = 15'h7ba1;
      5'd29: v = 15'h7bb9;
      5'd30: v = 15'h7bd1;
      5'd31: v = 15'h7be9;
      default: v = 15'h7800;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/fpld_norm.sv -----
// Three-stage normaliser: input capture, coarse shift (16/8), fine shift (4/2/1).
// Depends on fpld_pkg.
module fpld_norm (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              accept,
  input  logic [fpld_pkg::InWidth-1:0]      sample_value,
  output fpld_pkg::norm_t                   norm
);

  fpld_pkg::norm_t s1, s2, s3;
  fpld_pkg::norm_t s2_next, s3_next;

  // coarse: shift by 16 then 8 where the top bits are clear
  always_comb begin
    logic [fpld_pkg::MagWidth-1:0]   m;
    logic [fpld_pkg::ShiftWidth-1:0] s;
    m = s1.mag;
    s = '0;
    if (m[30:15] == '0) begin
      m = {m[14:0], 16'b0};
      s = s + 5'd16;
    end
    if (m[30:23] == '0) begin
      m = {m[22:0], 8'b0};
      s = s + 5'd8;
    end
    s2_next = s1;
    s2_next.mag = m;
    s2_next.shift = s;
  end

  // fine: 4, 2, 1
  always_comb begin
    logic [fpld_pkg::MagWidth-1:0]   m;
    logic [fpld_pkg::ShiftWidth-1:0] s;
    m = s2.mag;
    s = s2.shift;
    if (m[30:27] == '0) begin
      m = {m[26:0], 4'b0};
      s = s + 5'd4;
    end
    if (m[30:29] == '0) begin
      m = {m[28:0], 2'b0};
      s = s + 5'd2;
    end
    if (!m[30]) begin
      m = {m[29:0], 1'b0};
      s = s + 5'd1;
    end
    s3_next = s2;
    s3_next.mag = m;
    s3_next.shift = s;
  end

  always_ff @(posedge clk) begin
    s1.invalid <= (sample_value == '0) | sample_value[fpld_pkg::InWidth-1];
    s1.mag     <= sample_value[fpld_pkg::MagWidth-1:0];
    s1.shift   <= '0;
    s2.invalid <= s2_next.invalid;
    s2.mag     <= s2_next.mag;
    s2.shift   <= s2_next.shift;
    s3.invalid <= s3_next.invalid;
    s3.mag     <= s3_next.mag;
    s3.shift   <= s3_next.shift;
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
      s3.valid <= 1'b0;
    end else begin
      s1.valid <= accept;
      s2.valid <= s2_next.valid;
      s3.valid <= s3_next.valid;
    end
  end

  assign norm = s3;

endmodule

// ----- rtl/core/fpld_scale.sv -----
// Table lookup and scaling by 3.0103 (one stage), then subtract and output register.
// Depends on fpld_pkg.
module fpld_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  fpld_pkg::norm_t                   norm,
  output logic                              done,
  output logic [fpld_pkg::OutWidth-1:0]     level_db_q23,
  output logic                              invalid_input
);

  logic                              p_valid;
  logic                              p_invalid;
  logic [fpld_pkg::ProdWidth-1:0]    term_a;
  logic [fpld_pkg::ProdWidth-1:0]    term_b;
  logic [fpld_pkg::IdxWidth-1:0]     idx;
  logic [fpld_pkg::ProdWidth-1:0]    tab_ext;
  logic [fpld_pkg::ProdWidth-1:0]    shift_q10;
  logic [fpld_pkg::ProdWidth-1:0]    diff;

  assign idx       = norm.mag[fpld_pkg::IdxLsb +: fpld_pkg::IdxWidth];
  assign tab_ext   = fpld_pkg::ProdWidth'(fpld_pkg::log2_q10(idx));
  assign shift_q10 = fpld_pkg::ProdWidth'({norm.shift, 10'b0});
  assign diff      = term_a - term_b;

  always_ff @(posedge clk) begin
    term_a    <= tab_ext * fpld_pkg::DbScaleQ13;
    term_b    <= shift_q10 * fpld_pkg::DbScaleQ13;
    p_invalid <= norm.invalid;
    invalid_input <= p_invalid;
    level_db_q23  <= p_invalid ? '0 : diff[fpld_pkg::OutWidth-1:0];
    if (rst) begin
      p_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      p_valid <= norm.valid;
      done    <= p_valid;
    end
  end

endmodule

// ----- rtl/core/fixed_point_log10_db_top.sv -----
// Top level of the decibel level block: 10*log10 of a signed 32-bit value in Q23.
// Depends on fpld_pkg, fpld_norm and fpld_scale.
//
// One item may be started in every clock cycle: busy is held low, so an item
// is taken at each rising edge with start high. Each item gives exactly one
// result, shown with done high for one cycle as it leaves the last stage;
// the receiver cannot stall it, so results leave in input order at the input
// rate. The five stages are input capture, two normalising shift stages (16/8,
// then 4/2/1), table lookup with the two constant multiplies, and the final
// subtract. Zero or negative inputs give level 0 with invalid_input set. No
// state beyond the pipeline; reset clears the valid bits.
module fixed_point_log10_db_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [fpld_pkg::InWidth-1:0]      sample_value,
  output logic                              done,
  output logic [fpld_pkg::OutWidth-1:0]     level_db_q23,
  output logic                              invalid_input
);

  fpld_pkg::norm_t norm;
  logic            accept;

  // fully pipelined: never refuses an item
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  fpld_norm u_norm (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .sample_value (sample_value),
    .norm         (norm)
  );

  fpld_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .norm          (norm),
    .done          (done),
    .level_db_q23  (level_db_q23),
    .invalid_input (invalid_input)
  );

endmodule

// ----- sim/tb_fixed_point_log10_db_top.sv -----
// Testbench for fixed_point_log10_db_top: directed and random samples, each level
// predicted in a small scoreboard and checked in order. Depends on fpld_pkg and the RTL.
module tb_fixed_point_log10_db_top;

  // log2(1 + i/32) + 30 in Q10, entry 31 first
  localparam logic [32*15-1:0] Log2TabQ10 = {
    15'h7be9, 15'h7bd1, 15'h7bb9, 15'h7ba1, 15'h7b88, 15'h7b6f, 15'h7b55, 15'h7b3b,
    15'h7b20, 15'h7b05, 15'h7ae9, 15'h7acd, 15'h7ab1, 15'h7a93, 15'h7a75, 15'h7a57,
    15'h7a38, 15'h7a18, 15'h79f8, 15'h79d6, 15'h79b4, 15'h7992, 15'h796e, 15'h794a,
    15'h7924, 15'h78fe, 15'h78d6, 15'h78ae, 15'h7884, 15'h785a, 15'h782d, 15'h7800
  };
  localparam logic [31:0] DbScale     = 32'd24660;  // 3.0103 in Q13
  localparam int          WatchLimit  = 1000;       // cycles with nothing moving
  localparam int          RandPerPass = 425;

  typedef struct {
    logic [fpld_pkg::InWidth-1:0]  sample;
    logic [fpld_pkg::OutWidth-1:0] level;
    logic                          invalid;
  } level_t;

  class level_scoreboard;
    level_t   due_levels[$];
    int       n_samples, n_levels, n_invalid, n_errors;
    bit [30:0] shift_seen;
    bit [31:0] index_seen;

    // 10*log10 in Q23 via normalise, table lookup and two constant products
    function automatic level_t predict_level(input logic [fpld_pkg::InWidth-1:0] raw);
      level_t      p;
      logic [31:0] normed, term_a, term_b;
      int          sh;
      logic [4:0]  idx;
      p.sample = raw;
      if (raw == '0 || raw[31]) begin
        p.level   = '0;
        p.invalid = 1'b1;
        return p;
      end
      sh = 0;
      normed = raw;
      while (sh < 30 && !normed[30]) begin
        normed = {1'b0, normed[29:0], 1'b0};
        sh++;
      end
      idx    = normed[29:25];
      term_a = 32'(Log2TabQ10[idx*15 +: 15]) * DbScale;
      term_b = (32'(sh) << 10) * DbScale;
      p.level   = fpld_pkg::OutWidth'(term_a - term_b);
      p.invalid = 1'b0;
      shift_seen[sh]  = 1'b1;
      index_seen[idx] = 1'b1;
      return p;
    endfunction

    function void note_sample(input logic [fpld_pkg::InWidth-1:0] raw);
      due_levels.push_back(predict_level(raw));
      n_samples++;
    endfunction

    function void check_result(input logic [fpld_pkg::OutWidth-1:0] level,
                               input logic invalid);
      level_t e;
      if (due_levels.size() == 0) begin
        $display("%0t: result with nothing due: level %0d invalid %0b", $time, level, invalid);
        n_errors++;
        return;
      end
      e = due_levels.pop_front();
      n_levels++;
      if (e.invalid) n_invalid++;
      if (level !== e.level) begin
        $display("%0t: sample %h level expected %0d actual %0d",
                 $time, e.sample, e.level, level);
        n_errors++;
      end
      if (invalid !== e.invalid) begin
        $display("%0t: sample %h invalid_input expected %0b actual %0b",
                 $time, e.sample, e.invalid, invalid);
        n_errors++;
      end
    endfunction

    function int pending();
      return due_levels.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic                          busy;
  logic [fpld_pkg::InWidth-1:0]  sample_value;
  logic                          done;
  logic [fpld_pkg::OutWidth-1:0] level_db_q23;
  logic                          invalid_input;

  level_scoreboard sb = new();

  fixed_point_log10_db_top DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .sample_value  (sample_value),
    .done          (done),
    .level_db_q23  (level_db_q23),
    .invalid_input (invalid_input)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Everything is observed at the rising edge; inputs only move at the falling one,
  // so a sample taken and a result leaving at the same edge are seen in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_sample(sample_value);
      if (done) sb.check_result(level_db_q23, invalid_input);
    end
  end

  // Watchdog: any item taken or result shown counts as progress.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchLimit) begin
      @(posedge clk);
      if (rst || (start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("%0t: no progress for %0d cycles", $time, WatchLimit);
    $display("[fixed_point_log10_db_top] ERROR");
    $finish;
  end

  // Positive value with its top set bit at a random position, so every
  // normalising shift is hit about equally.
  function automatic logic [31:0] rand_positive();
    int unsigned k;
    logic [31:0] top;
    k   = $urandom_range(30);
    top = 32'h1 << k;
    return ($urandom & (top - 1)) | top;
  endfunction

  function automatic logic [31:0] pick_sample();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65)      return rand_positive();
    else if (r < 77) return $urandom;                       // any bit pattern
    else if (r < 87) return 32'h8000_0000 | $urandom;        // negative
    else if (r < 92) return '0;
    else if (r < 96) return 32'($urandom_range(16, 1));      // tiny, large shifts
    else             return 32'h7fff_ffff - $urandom_range(3);
  endfunction

  // Idles on a coin with idle_pct chance per cycle, then offers the item and
  // holds it until taken. Idle cycles carry junk data with start low.
  task automatic send_sample(input logic [31:0] v, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start        <= 1'b0;
      sample_value <= $urandom;
    end
    @(negedge clk);
    start        <= 1'b1;
    sample_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Stop offering and let the pipe empty out.
  task automatic drain_levels();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [31:0] directed[$];
    int          idle_plan[3];
    rst          = 1'b1;
    start        = 1'b0;
    sample_value = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: zero, negatives, unity, the largest value, table ends, and
    // top bits at both ends of the range.
    directed = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'haaaa_aaaa,
                 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_00ff,
                 32'h0000_0100, 32'h0000_ffff, 32'h0001_0000, 32'h0100_0000,
                 32'h2000_0000, 32'h3fff_ffff, 32'h4000_0000, 32'h4200_0000,
                 32'h5555_5555, 32'h7c00_0000, 32'h7e00_0000, 32'h7fff_ffff,
                 32'h8000_0001, 32'h7fff_fffe};
    foreach (directed[i]) send_sample(directed[i], 0);
    drain_levels();

    // Random passes: light sender gaps, then heavy, then back to back.
    // Each pass ends with the sender holding off until all levels are in.
    idle_plan = '{28, 80, 0};
    foreach (idle_plan[p]) begin
      repeat (RandPerPass) send_sample(pick_sample(), idle_plan[p]);
      drain_levels();
    end

    // Keep the clock running so that any stray result is still seen.
    repeat (12) @(posedge clk);

    $display("Checked %0d levels from %0d samples, %0d of them zero or negative.",
             sb.n_levels, sb.n_samples, sb.n_invalid);
    $display("Normalising shifts covered %0d of 31, table entries %0d of 32.",
             $countones(sb.shift_seen), $countones(sb.index_seen));
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("[fixed_point_log10_db_top] OK");
    end else begin
      $display("[fixed_point_log10_db_top] ERROR");
    end
    $finish;
  end

endmodule
